/* design/mer_pkg.sv */
// Package for the midpoint ellipse rasterizer.
// Holds default sizes, command codes, state and opcode types, and the
// command and status structs between controller and datapath.
package mer_pkg;

  localparam int DEF_RADIUS_BITS = 11;
  localparam int DEF_COORD_BITS  = 16;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RX,
    ST_SQ_RY,
    ST_SLOPE,
    ST_INIT,
    ST_E_AA,
    ST_E_RYA,
    ST_E_BB,
    ST_E_RXB,
    ST_E_RXRY,
    ST_E_DONE
  } mer_state_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_RX2_RY,
    MUL_A_A,
    MUL_RY2_P,
    MUL_B_B,
    MUL_RX2_P,
    MUL_RX2_RY2
  } mer_mul_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SAVE_RX2,
    OP_SAVE_RY2,
    OP_INIT,
    OP_DEC_LOAD,
    OP_DEC_ADD,
    OP_DEC_SUB
  } mer_op_t;

  typedef struct packed {
    logic     take_start;
    logic     take_step;
    mer_mul_t mul_sel;
    mer_op_t  op;
  } mer_cmd_t;

  typedef struct packed {
    logic enter_two;
    logic out_free;
  } mer_status_t;

endpackage

/* design/mer_item_if.sv */
// Input channel of the ellipse rasterizer: one command word per handshake.
// Stands alone; sizes come in as parameters.
interface mer_item_if #(
  parameter int RADIUS_BITS = 11,
  parameter int COORD_BITS  = 16
);
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic signed [COORD_BITS-2:0]   center_x;
  logic signed [COORD_BITS-2:0]   center_y;
  logic        [RADIUS_BITS-1:0]  radius_x;
  logic        [RADIUS_BITS-1:0]  radius_y;

  modport source (output valid, cmd, center_x, center_y, radius_x, radius_y,
                  input ready);
  modport sink (input valid, cmd, center_x, center_y, radius_x, radius_y,
                output ready);
endinterface

/* design/mer_point_if.sv */
// Output channel of the ellipse rasterizer: one symmetric point set per word.
// Stands alone; the coordinate width comes in as a parameter.
interface mer_point_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_right;
  logic signed [COORD_BITS-1:0] x_left;
  logic signed [COORD_BITS-1:0] y_top;
  logic signed [COORD_BITS-1:0] y_bottom;
  logic                         last;

  modport source (output valid, x_right, x_left, y_top, y_bottom, last,
                  input ready);
  modport sink (input valid, x_right, x_left, y_top, y_bottom, last,
                output ready);
endinterface

/* design/midpoint_ellipse_rasterizer.sv */
// Top level of the midpoint ellipse rasterizer: controller plus datapath.
// Depends on mer_pkg, mer_item_if, mer_point_if, mer_ctrl and mer_dpath.
//
//   channel | dir | word contents
//   item    | in  | cmd, center_x, center_y, radius_x, radius_y
//   point   | out | x_right, x_left, y_top, y_bottom, last
//
// A step word's point set appears in the output register on the next cycle.
// A start word runs setup states SQ_RX, SQ_RY, SLOPE and INIT, the squares
// and the initial decision term going through the single shared multiplier
// one product per cycle. When a step, or a start with a zero semi-axis,
// reaches region two, ready stays low as the controller sees the switch and
// forms the region-two decision term in E_AA to E_DONE, all but E_DONE products.
// Reset clears the controller, the in-progress flags and the output valid.
// Input ready drops while the output register holds a word not yet taken.
module midpoint_ellipse_rasterizer
  import mer_pkg::*;
#(
  parameter int RADIUS_BITS = DEF_RADIUS_BITS,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic       clk,
  input  logic       rst,
  mer_item_if.sink   item,
  mer_point_if.source point
);

  mer_cmd_t    cmd;
  mer_status_t status;
  logic        ready;

  assign item.ready = ready;

  mer_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_cmd   (item.cmd),
    .status     (status),
    .ready      (ready),
    .cmd        (cmd)
  );

  mer_dpath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .item_center_x (item.center_x),
    .item_center_y (item.center_y),
    .item_radius_x (item.radius_x),
    .item_radius_y (item.radius_y),
    .point_valid   (point.valid),
    .point_ready   (point.ready),
    .x_right       (point.x_right),
    .x_left        (point.x_left),
    .y_top         (point.y_top),
    .y_bottom      (point.y_bottom),
    .last          (point.last)
  );

endmodule

/* design/mer_ctrl.sv */
// Controller of the ellipse rasterizer: sequences the shared multiplier for
// setup and for the region switch. Depends on mer_pkg.
module mer_ctrl
  import mer_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_cmd,
  input  mer_status_t status,
  output logic        ready,
  output mer_cmd_t    cmd
);

  mer_state_t state;
  mer_state_t state_next;
  logic       accept;

  assign accept = item_valid && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && item_cmd == CMD_START) begin
          state_next = ST_SQ_RX;
        end else if (status.enter_two) begin
          state_next = ST_E_AA;
        end
      end
      ST_SQ_RX:  state_next = ST_SQ_RY;
      ST_SQ_RY:  state_next = ST_SLOPE;
      ST_SLOPE:  state_next = ST_INIT;
      ST_INIT:   state_next = ST_IDLE;
      ST_E_AA:   state_next = ST_E_RYA;
      ST_E_RYA:  state_next = ST_E_BB;
      ST_E_BB:   state_next = ST_E_RXB;
      ST_E_RXB:  state_next = ST_E_RXRY;
      ST_E_RXRY: state_next = ST_E_DONE;
      ST_E_DONE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ready          = 1'b0;
    cmd.take_start = 1'b0;
    cmd.take_step  = 1'b0;
    cmd.mul_sel    = MUL_NONE;
    cmd.op         = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        ready          = !status.enter_two && status.out_free;
        cmd.take_start = item_valid && ready && item_cmd == CMD_START;
        cmd.take_step  = item_valid && ready && item_cmd == CMD_STEP;
      end
      ST_SQ_RX: cmd.mul_sel = MUL_RX_RX;
      ST_SQ_RY: begin
        cmd.mul_sel = MUL_RY_RY;
        cmd.op      = OP_SAVE_RX2;
      end
      ST_SLOPE: begin
        cmd.mul_sel = MUL_RX2_RY;
        cmd.op      = OP_SAVE_RY2;
      end
      ST_INIT:  cmd.op = OP_INIT;
      ST_E_AA:  cmd.mul_sel = MUL_A_A;
      ST_E_RYA: cmd.mul_sel = MUL_RY2_P;
      ST_E_BB: begin
        cmd.mul_sel = MUL_B_B;
        cmd.op      = OP_DEC_LOAD;
      end
      ST_E_RXB: cmd.mul_sel = MUL_RX2_P;
      ST_E_RXRY: begin
        cmd.mul_sel = MUL_RX2_RY2;
        cmd.op      = OP_DEC_ADD;
      end
      ST_E_DONE: cmd.op = OP_DEC_SUB;
      default: begin
        ready = 1'b0;
      end
    endcase
  end

  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.take_start |=> state == ST_SQ_RX)
    else $error("start did not enter the setup sequence");

  a_switch_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_E_DONE |=> !status.enter_two)
    else $error("region switch requested again after it completed");

endmodule

/* design/mer_dpath.sv */
// Datapath of the ellipse rasterizer: position, slope and decision registers,
// one shared multiplier and the output word register. Depends on mer_pkg.
module mer_dpath
  import mer_pkg::*;
#(
  parameter int RADIUS_BITS = DEF_RADIUS_BITS,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mer_cmd_t                      cmd,
  output mer_status_t                   status,
  input  logic signed [COORD_BITS-2:0]  item_center_x,
  input  logic signed [COORD_BITS-2:0]  item_center_y,
  input  logic        [RADIUS_BITS-1:0] item_radius_x,
  input  logic        [RADIUS_BITS-1:0] item_radius_y,
  output logic                          point_valid,
  input  logic                          point_ready,
  output logic signed [COORD_BITS-1:0]  x_right,
  output logic signed [COORD_BITS-1:0]  x_left,
  output logic signed [COORD_BITS-1:0]  y_top,
  output logic signed [COORD_BITS-1:0]  y_bottom,
  output logic                          last
);

  localparam int SQW = 2 * RADIUS_BITS;
  localparam int OXW = RADIUS_BITS + 1;
  localparam int OYW = RADIUS_BITS + 2;
  localparam int STW = 3 * RADIUS_BITS + 3;
  localparam int MW  = 2 * RADIUS_BITS + 4;
  localparam int DW  = 2 * MW;
  localparam int SW  = ((COORD_BITS > OYW) ? COORD_BITS : OYW) + 1;

  logic                  active;
  logic                  in_region_two;
  logic [COORD_BITS-2:0] center_x;
  logic [COORD_BITS-2:0] center_y;
  logic [RADIUS_BITS-1:0] rad_x;
  logic [RADIUS_BITS-1:0] rad_y;
  logic [SQW-1:0]        rx2;
  logic [SQW-1:0]        ry2;
  logic [OXW-1:0]        offset_x;
  logic [OYW-1:0]        offset_y;
  logic [STW-1:0]        slope_x;
  logic [STW-1:0]        slope_y;
  logic [DW-1:0]         decision;
  logic [DW-1:0]         prod;

  logic [MW-1:0]   mul_a;
  logic [MW-1:0]   mul_b;
  logic [OYW-1:0]  b_val;
  logic [OYW-1:0]  b_mag;
  logic [STW-1:0]  sx_add;
  logic [STW-1:0]  sy_sub;
  logic [DW-1:0]   sx_ext;
  logic [DW-1:0]   sy_ext;
  logic [DW-1:0]   rx2_ext;
  logic [DW-1:0]   ry2_ext;
  logic [DW-1:0]   dec_inc;
  logic [OXW-1:0]  offset_x_next;
  logic [OYW-1:0]  offset_y_next;
  logic [STW-1:0]  slope_x_next;
  logic [STW-1:0]  slope_y_next;
  logic [DW-1:0]   decision_next;
  logic [SW-1:0]   cx_ext;
  logic [SW-1:0]   cy_ext;
  logic [SW-1:0]   ox_ext;
  logic [SW-1:0]   oy_ext;
  logic [SW-1:0]   sum_xr;
  logic [SW-1:0]   sum_xl;
  logic [SW-1:0]   sum_yt;
  logic [SW-1:0]   sum_yb;
  logic            step_live;

  assign step_live = cmd.take_step && active;

  assign status.enter_two = active && !in_region_two && !(slope_x < slope_y);
  assign status.out_free  = !point_valid || point_ready;

  assign b_val = offset_y - OYW'(1);
  assign b_mag = b_val[OYW-1] ? (~b_val + OYW'(1)) : b_val;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      MUL_RX_RX: begin
        mul_a = MW'(rad_x);
        mul_b = MW'(rad_x);
      end
      MUL_RY_RY: begin
        mul_a = MW'(rad_y);
        mul_b = MW'(rad_y);
      end
      MUL_RX2_RY: begin
        mul_a = MW'(rx2);
        mul_b = MW'(rad_y);
      end
      MUL_A_A: begin
        mul_a = MW'({offset_x, 1'b1});
        mul_b = MW'({offset_x, 1'b1});
      end
      MUL_RY2_P: begin
        mul_a = MW'(ry2);
        mul_b = prod[MW-1:0];
      end
      MUL_B_B: begin
        mul_a = MW'(b_mag);
        mul_b = MW'(b_mag);
      end
      MUL_RX2_P: begin
        mul_a = MW'(rx2);
        mul_b = prod[MW-1:0];
      end
      MUL_RX2_RY2: begin
        mul_a = MW'(rx2);
        mul_b = MW'(ry2);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sx_add  = slope_x + STW'({ry2, 1'b0});
  assign sy_sub  = slope_y - STW'({rx2, 1'b0});
  assign sx_ext  = {{(DW-STW){sx_add[STW-1]}}, sx_add};
  assign sy_ext  = {{(DW-STW){sy_sub[STW-1]}}, sy_sub};
  assign rx2_ext = DW'(rx2);
  assign ry2_ext = DW'(ry2);

  always_comb begin
    offset_x_next = offset_x;
    offset_y_next = offset_y;
    slope_x_next  = slope_x;
    slope_y_next  = slope_y;
    dec_inc       = '0;
    if (!in_region_two) begin
      offset_x_next = offset_x + OXW'(1);
      slope_x_next  = sx_add;
      if (decision[DW-1]) begin
        dec_inc = sx_ext + ry2_ext;
      end else begin
        offset_y_next = b_val;
        slope_y_next  = sy_sub;
        dec_inc       = sx_ext - sy_ext + ry2_ext;
      end
    end else begin
      offset_y_next = b_val;
      slope_y_next  = sy_sub;
      if (!decision[DW-1] && decision != '0) begin
        dec_inc = rx2_ext - sy_ext;
      end else begin
        offset_x_next = offset_x + OXW'(1);
        slope_x_next  = sx_add;
        dec_inc       = sx_ext - sy_ext + rx2_ext;
      end
    end
    decision_next = decision + {dec_inc[DW-3:0], 2'b00};
  end

  assign cx_ext = {{(SW-COORD_BITS+1){center_x[COORD_BITS-2]}}, center_x};
  assign cy_ext = {{(SW-COORD_BITS+1){center_y[COORD_BITS-2]}}, center_y};
  assign ox_ext = SW'(offset_x);
  assign oy_ext = {{(SW-OYW){offset_y[OYW-1]}}, offset_y};
  assign sum_xr = cx_ext + ox_ext;
  assign sum_xl = cx_ext - ox_ext;
  assign sum_yt = cy_ext + oy_ext;
  assign sum_yb = cy_ext - oy_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      in_region_two <= 1'b0;
      point_valid   <= 1'b0;
    end else begin
      if (cmd.take_start) begin
        active        <= 1'b1;
        in_region_two <= 1'b0;
      end else if (step_live) begin
        active <= !(in_region_two && offset_y == '0);
      end else if (cmd.op == OP_DEC_SUB) begin
        in_region_two <= 1'b1;
      end
      if (step_live) begin
        point_valid <= 1'b1;
      end else if (point_ready) begin
        point_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MUL_NONE) begin
      prod <= DW'(mul_a) * DW'(mul_b);
    end
    if (step_live) begin
      x_right  <= sum_xr[COORD_BITS-1:0];
      x_left   <= sum_xl[COORD_BITS-1:0];
      y_top    <= sum_yt[COORD_BITS-1:0];
      y_bottom <= sum_yb[COORD_BITS-1:0];
      last     <= in_region_two && offset_y == '0;
    end
    if (cmd.take_start) begin
      center_x <= item_center_x;
      center_y <= item_center_y;
      rad_x    <= item_radius_x;
      rad_y    <= item_radius_y;
      offset_x <= '0;
      offset_y <= OYW'(item_radius_y);
      slope_x  <= '0;
    end else if (step_live) begin
      offset_x <= offset_x_next;
      offset_y <= offset_y_next;
      slope_x  <= slope_x_next;
      slope_y  <= slope_y_next;
      decision <= decision_next;
    end else begin
      case (cmd.op)
        OP_SAVE_RX2: rx2 <= prod[SQW-1:0];
        OP_SAVE_RY2: ry2 <= prod[SQW-1:0];
        OP_INIT: begin
          slope_y  <= {prod[STW-2:0], 1'b0};
          decision <= {ry2_ext[DW-3:0], 2'b00} - {prod[DW-3:0], 2'b00} + rx2_ext;
        end
        OP_DEC_LOAD: decision <= prod;
        OP_DEC_ADD:  decision <= decision + {prod[DW-3:0], 2'b00};
        OP_DEC_SUB:  decision <= decision - {prod[DW-3:0], 2'b00};
        default: begin
          decision <= decision;
        end
      endcase
    end
  end

  a_step_word: assert property (@(posedge clk) disable iff (rst)
    step_live |=> point_valid)
    else $error("step on a live ellipse produced no word");

  a_region_hold: assert property (@(posedge clk) disable iff (rst)
    $fell(in_region_two) |-> $past(cmd.take_start) || $past(rst))
    else $error("region two left without a start");

  a_offset_floor: assert property (@(posedge clk) disable iff (rst)
    active && offset_y[OYW-1] |-> offset_y == '1)
    else $error("vertical offset went below minus one on a live ellipse");

endmodule

/* verif/tb_top.sv */
// Testbench for the midpoint ellipse rasterizer: sends start and step words, predicts
// every point set from a software trace of the ellipse and checks each word as it leaves.
// Depends on mer_pkg, mer_item_if, mer_point_if and midpoint_ellipse_rasterizer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mer_pkg::*;

  localparam int RADIUS_W    = DEF_RADIUS_BITS;
  localparam int COORD_W     = DEF_COORD_BITS;
  localparam int CENTER_W    = COORD_W - 1;
  localparam int IDLE_PCT    = 28;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;
  localparam int OPEN_ENDED  = 1 << 20;

  localparam logic signed [CENTER_W-1:0] CENTER_MIN = {1'b1, {(CENTER_W-1){1'b0}}};
  localparam logic signed [CENTER_W-1:0] CENTER_MAX = {1'b0, {(CENTER_W-1){1'b1}}};
  localparam logic [RADIUS_W-1:0]        RADIUS_MAX = '1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_right;
    logic signed [COORD_W-1:0] x_left;
    logic signed [COORD_W-1:0] y_top;
    logic signed [COORD_W-1:0] y_bottom;
    logic                      last;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        tr_active;
  logic        tr_region_two;
  longint      tr_center_x;
  longint      tr_center_y;
  longint      tr_off_x;
  longint      tr_off_y;
  logic [63:0] tr_rx_sq;
  logic [63:0] tr_ry_sq;
  logic [63:0] tr_slope_x;
  logic [63:0] tr_slope_y;
  logic [63:0] tr_decision;

  point_t pending_points[$];
  int     mismatches   = 0;
  int     useful_items = 0;
  int     stall_cycles = 0;
  bit     steady       = 1'b0;

  mer_item_if #(.RADIUS_BITS(RADIUS_W), .COORD_BITS(COORD_W)) item_bus ();
  mer_point_if #(.COORD_BITS(COORD_W)) point_bus ();

  midpoint_ellipse_rasterizer #(
    .RADIUS_BITS(RADIUS_W),
    .COORD_BITS (COORD_W)
  ) uut (
    .clk  (clk),
    .rst  (rst),
    .item (item_bus),
    .point(point_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Switches to region two once the slopes cross, and ends the ellipse below the axis.
  function automatic void settle_trace();
    logic [63:0] a;
    logic [63:0] b;
    if (tr_active && !tr_region_two && !(tr_slope_x < tr_slope_y)) begin
      a = 64'(2 * tr_off_x + 1);
      b = 64'(tr_off_y - 1);
      tr_region_two = 1'b1;
      tr_decision = tr_ry_sq * a * a + 64'd4 * tr_rx_sq * b * b
                  - 64'd4 * tr_rx_sq * tr_ry_sq;
    end
    if (tr_active && tr_region_two && tr_off_y < 0) begin
      tr_active = 1'b0;
    end
  endfunction

  function automatic bit trace_word(input logic cmd, input logic signed [CENTER_W-1:0] cx,
                                    input logic signed [CENTER_W-1:0] cy,
                                    input logic [RADIUS_W-1:0] rx,
                                    input logic [RADIUS_W-1:0] ry, output point_t pt);
    pt = '0;
    if (cmd == CMD_START) begin
      tr_center_x   = cx;
      tr_center_y   = cy;
      tr_rx_sq      = 64'(rx) * 64'(rx);
      tr_ry_sq      = 64'(ry) * 64'(ry);
      tr_off_x      = 0;
      tr_off_y      = ry;
      tr_slope_x    = '0;
      tr_slope_y    = 64'd2 * tr_rx_sq * 64'(ry);
      tr_decision   = 64'd4 * tr_ry_sq - 64'd4 * tr_rx_sq * 64'(ry) + tr_rx_sq;
      tr_region_two = 1'b0;
      tr_active     = 1'b1;
      settle_trace();
      return 1'b0;
    end
    if (!tr_active) begin
      return 1'b0;
    end
    pt.x_right  = COORD_W'(tr_center_x + tr_off_x);
    pt.x_left   = COORD_W'(tr_center_x - tr_off_x);
    pt.y_top    = COORD_W'(tr_center_y + tr_off_y);
    pt.y_bottom = COORD_W'(tr_center_y - tr_off_y);
    if (!tr_region_two) begin
      tr_off_x++;
      tr_slope_x += 64'd2 * tr_ry_sq;
      if (tr_decision[63]) begin
        tr_decision += 64'd4 * (tr_slope_x + tr_ry_sq);
      end else begin
        tr_off_y--;
        tr_slope_y -= 64'd2 * tr_rx_sq;
        tr_decision += 64'd4 * (tr_slope_x - tr_slope_y + tr_ry_sq);
      end
    end else begin
      tr_off_y--;
      tr_slope_y -= 64'd2 * tr_rx_sq;
      if (!tr_decision[63] && tr_decision != 0) begin
        tr_decision += 64'd4 * (tr_rx_sq - tr_slope_y);
      end else begin
        tr_off_x++;
        tr_slope_x += 64'd2 * tr_ry_sq;
        tr_decision += 64'd4 * (tr_slope_x - tr_slope_y + tr_rx_sq);
      end
    end
    settle_trace();
    pt.last = !tr_active;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("mismatch at %0t ns: %s got %0d expected %0d", $time, field, got, want);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic cmd, input logic signed [CENTER_W-1:0] cx,
                           input logic signed [CENTER_W-1:0] cy,
                           input logic [RADIUS_W-1:0] rx, input logic [RADIUS_W-1:0] ry);
    point_t pt;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      item_bus.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    item_bus.valid    <= 1'b1;
    item_bus.cmd      <= cmd;
    item_bus.center_x <= cx;
    item_bus.center_y <= cy;
    item_bus.radius_x <= rx;
    item_bus.radius_y <= ry;
    do @(posedge clk); while (item_bus.ready !== 1'b1);
    if (cmd == CMD_START || tr_active) begin
      useful_items++;
    end
    if (trace_word(cmd, cx, cy, rx, ry, pt)) begin
      pending_points.push_back(pt);
    end
    @(negedge clk);
  endtask

  task automatic send_noise_step();
    send_word(CMD_STEP, CENTER_W'($urandom), CENTER_W'($urandom), RADIUS_W'($urandom),
              RADIUS_W'($urandom));
  endtask

  task automatic draw_ellipse(input logic signed [CENTER_W-1:0] cx,
                              input logic signed [CENTER_W-1:0] cy,
                              input logic [RADIUS_W-1:0] rx, input logic [RADIUS_W-1:0] ry,
                              input int max_steps);
    int n;
    send_word(CMD_START, cx, cy, rx, ry);
    n = 0;
    while (tr_active && n < max_steps) begin
      send_noise_step();
      n++;
    end
  endtask

  task automatic random_ellipse();
    int                  pick;
    int                  cap;
    logic [RADIUS_W-1:0] rx;
    logic [RADIUS_W-1:0] ry;
    pick = $urandom_range(99);
    if (pick < 78) begin
      rx  = RADIUS_W'($urandom_range(15));
      ry  = RADIUS_W'($urandom_range(15));
      cap = OPEN_ENDED;
    end else if (pick < 90) begin
      rx  = RADIUS_W'($urandom_range(127));
      ry  = RADIUS_W'($urandom_range(127));
      cap = OPEN_ENDED;
    end else begin
      rx  = RADIUS_W'($urandom);
      ry  = RADIUS_W'($urandom);
      cap = $urandom_range(1, 24);
    end
    if ($urandom_range(9) == 0) begin
      cap = $urandom_range(0, 6);
    end
    draw_ellipse(CENTER_W'($urandom), CENTER_W'($urandom), rx, ry, cap);
    if ($urandom_range(3) == 0) begin
      send_noise_step();
    end
  endtask

  task automatic wait_for_points();
    item_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending_points.size() != 0) @(negedge clk);
  endtask

  task automatic test_idle_steps();
    send_noise_step();
    send_noise_step();
  endtask

  task automatic test_zero_axes();
    draw_ellipse('0, '0, '0, '0, OPEN_ENDED);
    send_noise_step();
    draw_ellipse(CENTER_W'(100), -CENTER_W'(100), '0, RADIUS_W'(3), OPEN_ENDED);
    draw_ellipse(-CENTER_W'(5), CENTER_W'(7), RADIUS_W'(5), '0, OPEN_ENDED);
  endtask

  task automatic test_extreme_fields();
    draw_ellipse(CENTER_MIN, CENTER_MAX, RADIUS_MAX, RADIUS_MAX, 4);
    draw_ellipse(CENTER_MAX, CENTER_MAX, RADIUS_MAX, RADIUS_W'(1), 3);
  endtask

  // The start lands while the previous ellipse is still in progress.
  task automatic test_restart_midway();
    draw_ellipse(CENTER_MAX, CENTER_MIN, RADIUS_W'(40), RADIUS_MAX, 3);
  endtask

  task automatic test_random_ellipses(input int count);
    int target;
    target = useful_items + count;
    while (useful_items < target) random_ellipse();
  endtask

  task automatic test_drain_pause();
    random_ellipse();
    wait_for_points();
    random_ellipse();
  endtask

  task automatic test_steady_stretch(input int count);
    steady = 1'b1;
    test_random_ellipses(count);
    steady = 1'b0;
  endtask

  always @(negedge clk) begin
    point_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst && point_bus.valid === 1'b1 && point_bus.ready === 1'b1) begin
      if (pending_points.size() == 0) begin
        report_mismatch("point word with none expected, x_right", point_bus.x_right, 0);
      end else begin
        want = pending_points.pop_front();
        if (point_bus.x_right !== want.x_right) begin
          report_mismatch("x_right", point_bus.x_right, want.x_right);
        end
        if (point_bus.x_left !== want.x_left) begin
          report_mismatch("x_left", point_bus.x_left, want.x_left);
        end
        if (point_bus.y_top !== want.y_top) begin
          report_mismatch("y_top", point_bus.y_top, want.y_top);
        end
        if (point_bus.y_bottom !== want.y_bottom) begin
          report_mismatch("y_bottom", point_bus.y_bottom, want.y_bottom);
        end
        if (point_bus.last !== want.last) begin
          report_mismatch("last", point_bus.last, want.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
        (point_bus.valid === 1'b1 && point_bus.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    tr_active          = 1'b0;
    tr_region_two      = 1'b0;
    tr_center_x        = 0;
    tr_center_y        = 0;
    tr_off_x           = 0;
    tr_off_y           = 0;
    tr_rx_sq           = '0;
    tr_ry_sq           = '0;
    tr_slope_x         = '0;
    tr_slope_y         = '0;
    tr_decision        = '0;
    item_bus.valid     = 1'b0;
    item_bus.cmd       = CMD_STEP;
    item_bus.center_x  = '0;
    item_bus.center_y  = '0;
    item_bus.radius_x  = '0;
    item_bus.radius_y  = '0;
    point_bus.ready    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_idle_steps();
    test_zero_axes();
    test_extreme_fields();
    test_restart_midway();
    test_random_ellipses(600);
    test_drain_pause();
    test_steady_stretch(200);
    test_random_ellipses(450);

    item_bus.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
